// File: design/apfpc_pkg.sv
`timescale 1ns / 1ps

package apfpc_pkg;

  // ring store geometry
  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // frame bytes
  localparam logic [7:0] DELIMITER  = 8'h7E;
  localparam logic [7:0] CHECK_BASE = 8'hFF;

  // field widths
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 16;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
  localparam int OQ_LIMIT = 3;

  // commands
  localparam logic CMD_PARSE = 1'b0;
  localparam logic CMD_POP   = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_TAKEN      = 3'd0,
    ST_GOOD       = 3'd1,
    ST_BAD        = 3'd2,
    ST_FULL       = 3'd3,
    ST_IGNORED    = 3'd4,
    ST_READ_OK    = 3'd5,
    ST_READ_EMPTY = 3'd6
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  rd_byte;
  } result_t;

endpackage

// File: design/apfpc_ram.sv
`timescale 1ns / 1ps

module apfpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/api_frame_parser_checksum.sv
`timescale 1ns / 1ps

// Frame parser with checksum check: each input beat is either a received serial
// byte or a pop command, and each gives exactly one result beat. Parse bytes walk
// the frame (0x7E delimiter, length high, length low, data bytes, checksum) and
// every frame byte that finds room goes into a 256-byte ring store held in a
// single-port-write, single-port-read RAM. A good checksum keeps the frame and
// reports the byte count, a bad one empties the store, a pop returns the oldest
// stored byte. One beat is accepted every cycle while in_stall is low; pointers,
// count and parse state update in the accept cycle, the RAM read of a pop lands in
// the cycle after. A small result queue lets input keep flowing while the output
// side stalls; input stalls only once three results are waiting or in flight.
module api_frame_parser_checksum (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [8:0] out_stored_count,
  output logic [7:0] out_read_byte
);

  localparam int PTR_W = apfpc_pkg::PTR_W;
  localparam int CNT_W = apfpc_pkg::CNT_W;

  // parse and ring control state
  apfpc_pkg::phase_t                  phase_r, phase_nxt;
  logic [apfpc_pkg::LEN_W-1:0]        remain_r, remain_nxt;
  logic [7:0]                         sum_r, sum_nxt;
  logic [PTR_W-1:0]                   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]                   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]                   fill_r, fill_nxt;

  // read stage
  logic                               p1_valid_r;
  apfpc_pkg::status_t                 p1_status_r;
  logic [apfpc_pkg::COUNT_W-1:0]      p1_count_r;
  logic                               p1_pop_r;

  // result queue
  apfpc_pkg::result_t                 oq_mem_r [apfpc_pkg::OQ_DEPTH];
  logic [apfpc_pkg::OQ_PTR_W-1:0]     oq_head_r, oq_tail_r;
  logic [apfpc_pkg::OQ_CNT_W-1:0]     oq_cnt_r;

  logic                               in_accept;
  logic                               out_accept;
  logic                               is_pop;
  logic                               full;
  logic                               push;
  logic                               pop_ok;
  logic [apfpc_pkg::LEN_W-1:0]        remain_dec;
  logic [PTR_W-1:0]                   wr_ptr_inc;
  logic [PTR_W-1:0]                   rd_ptr_inc;
  apfpc_pkg::status_t                 status_c;
  logic [7:0]                         ram_rdata;
  apfpc_pkg::result_t                 p1_result;
  logic [apfpc_pkg::OQ_CNT_W:0]       inflight;

  assign inflight   = {1'b0, oq_cnt_r} + {{apfpc_pkg::OQ_CNT_W{1'b0}}, p1_valid_r};
  assign in_stall   = (inflight >= (apfpc_pkg::OQ_CNT_W + 1)'(apfpc_pkg::OQ_LIMIT));
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (oq_cnt_r != '0);
  assign out_accept = out_valid && !out_stall;

  assign is_pop     = (in_command == apfpc_pkg::CMD_POP);
  assign full       = (fill_r >= CNT_W'(apfpc_pkg::RING_DEPTH));
  assign pop_ok     = in_accept && is_pop && (fill_r != '0);
  assign remain_dec = (remain_r != '0) ? remain_r - 1'b1 : remain_r;
  assign wr_ptr_inc = (wr_ptr_r == PTR_W'(apfpc_pkg::RING_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PTR_W'(apfpc_pkg::RING_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  // a parse byte is stored unless the store is full or it is a stray idle byte
  assign push = in_accept && !is_pop && !full &&
                ((phase_r != apfpc_pkg::PH_IDLE) || (in_data_byte == apfpc_pkg::DELIMITER));

  // parse phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (in_accept && !is_pop && !full) begin
      case (phase_r)
        apfpc_pkg::PH_IDLE: begin
          if (in_data_byte == apfpc_pkg::DELIMITER) begin
            phase_nxt = apfpc_pkg::PH_LEN_HI;
          end
        end
        apfpc_pkg::PH_LEN_HI: phase_nxt = apfpc_pkg::PH_LEN_LO;
        apfpc_pkg::PH_LEN_LO: begin
          phase_nxt = ({remain_r[15:8], in_data_byte} == '0) ? apfpc_pkg::PH_CHECK
                                                             : apfpc_pkg::PH_DATA;
        end
        apfpc_pkg::PH_DATA: begin
          if (remain_dec == '0) begin
            phase_nxt = apfpc_pkg::PH_CHECK;
          end
        end
        apfpc_pkg::PH_CHECK: phase_nxt = apfpc_pkg::PH_IDLE;
        default:             phase_nxt = apfpc_pkg::PH_IDLE;
      endcase
    end
  end

  // length, sum, pointers, count and status of this beat
  always_comb begin
    remain_nxt = remain_r;
    sum_nxt    = sum_r;
    wr_ptr_nxt = push ? wr_ptr_inc : wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    status_c   = apfpc_pkg::ST_TAKEN;
    if (is_pop) begin
      if (fill_r == '0) begin
        status_c = apfpc_pkg::ST_READ_EMPTY;
      end else begin
        status_c   = apfpc_pkg::ST_READ_OK;
        rd_ptr_nxt = rd_ptr_inc;
        fill_nxt   = fill_r - 1'b1;
      end
    end else if (full) begin
      status_c = apfpc_pkg::ST_FULL;
    end else begin
      if (push) begin
        fill_nxt = fill_r + 1'b1;
      end
      case (phase_r)
        apfpc_pkg::PH_IDLE: begin
          if (in_data_byte != apfpc_pkg::DELIMITER) begin
            status_c = apfpc_pkg::ST_IGNORED;
          end
        end
        apfpc_pkg::PH_LEN_HI: begin
          remain_nxt = {in_data_byte, 8'h00};
          sum_nxt    = '0;
        end
        apfpc_pkg::PH_LEN_LO: remain_nxt = {remain_r[15:8], in_data_byte};
        apfpc_pkg::PH_DATA: begin
          sum_nxt    = sum_r + in_data_byte;
          remain_nxt = remain_dec;
        end
        apfpc_pkg::PH_CHECK: begin
          if ((apfpc_pkg::CHECK_BASE - sum_r) == in_data_byte) begin
            status_c = apfpc_pkg::ST_GOOD;
          end else begin
            status_c   = apfpc_pkg::ST_BAD;
            rd_ptr_nxt = wr_ptr_inc;
            fill_nxt   = '0;
          end
          remain_nxt = '0;
          sum_nxt    = '0;
        end
        default: status_c = apfpc_pkg::ST_IGNORED;
      endcase
    end
  end

  // control state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= apfpc_pkg::PH_IDLE;
      remain_r <= '0;
      sum_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      sum_r    <= sum_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // ring store
  apfpc_ram #(
    .WIDTH (8),
    .DEPTH (apfpc_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr_r),
    .wdata (in_data_byte),
    .re    (pop_ok),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // read stage waits for the ram data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_status_r <= status_c;
      p1_count_r  <= apfpc_pkg::COUNT_W'(fill_nxt);
      p1_pop_r    <= pop_ok;
    end
  end

  assign p1_result.status  = p1_status_r;
  assign p1_result.count   = p1_count_r;
  assign p1_result.rd_byte = p1_pop_r ? ram_rdata : 8'h00;

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_head_r <= '0;
      oq_tail_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      if (p1_valid_r) begin
        oq_tail_r <= oq_tail_r + 1'b1;
      end
      if (out_accept) begin
        oq_head_r <= oq_head_r + 1'b1;
      end
      case ({p1_valid_r, out_accept})
        2'b10:   oq_cnt_r <= oq_cnt_r + 1'b1;
        2'b01:   oq_cnt_r <= oq_cnt_r - 1'b1;
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

  // result queue entries
  always_ff @(posedge clk) begin
    if (p1_valid_r) begin
      oq_mem_r[oq_tail_r] <= p1_result;
    end
  end

  assign out_status       = oq_mem_r[oq_head_r].status;
  assign out_stored_count = oq_mem_r[oq_head_r].count;
  assign out_read_byte    = oq_mem_r[oq_head_r].rd_byte;

endmodule
